### design/bcae_pkg.sv
// Package for the byte CPU execute unit: instruction codes, payload structs
// and the architectural register bundle. No dependencies.

package bcae_pkg;

  localparam int unsigned DataW = 8;
  localparam int unsigned AddrW = 16;
  localparam int unsigned OpW   = 5;

  typedef enum logic [OpW-1:0] {
    OP_LDA = 5'd0,
    OP_LDX = 5'd1,
    OP_LDY = 5'd2,
    OP_STA = 5'd3,
    OP_STX = 5'd4,
    OP_STY = 5'd5,
    OP_AND = 5'd6,
    OP_EOR = 5'd7,
    OP_ORA = 5'd8,
    OP_BIT = 5'd9,
    OP_ADC = 5'd10,
    OP_SBC = 5'd11,
    OP_CMP = 5'd12,
    OP_CPX = 5'd13,
    OP_CPY = 5'd14,
    OP_INC = 5'd15,
    OP_DEC = 5'd16
  } opcode_t;

  typedef struct packed {
    logic [OpW-1:0]   req_type;
    logic [AddrW-1:0] operand_address;
    logic [DataW-1:0] mem_data;
  } req_t;

  typedef struct packed {
    logic             write_enable;
    logic [AddrW-1:0] write_address;
    logic [DataW-1:0] write_data;
    logic [DataW-1:0] acc_out;
    logic [DataW-1:0] index_x_out;
    logic [DataW-1:0] index_y_out;
    logic             negative_flag;
    logic             overflow_flag;
    logic             zero_flag;
    logic             carry_flag;
  } rsp_t;

  // Architectural registers and flags
  typedef struct packed {
    logic [DataW-1:0] acc;
    logic [DataW-1:0] idx_x;
    logic [DataW-1:0] idx_y;
    logic             n;
    logic             v;
    logic             z;
    logic             c;
  } arch_t;

endpackage

### design/bcae_alu.sv
// Combinational instruction datapath: decode, 8-bit adder, logic ops and
// flag generation. Depends on bcae_pkg.

module bcae_alu import bcae_pkg::*; (
  input  req_t  req,
  input  arch_t cur,
  output rsp_t  rsp
);

  opcode_t          op;
  logic [DataW-1:0] m;
  logic [DataW-1:0] add_b;
  logic [DataW:0]   sum;
  logic [DataW-1:0] cmp_reg;
  logic [DataW:0]   diff;
  logic [DataW-1:0] inc_val;
  logic [DataW-1:0] dec_val;
  arch_t            nxt;
  logic             we;
  logic [DataW-1:0] wd;

  assign op      = opcode_t'(req.req_type);
  assign m       = req.mem_data;

  // SBC adds the one's complement of the operand
  assign add_b   = (op == OP_SBC) ? ~m : m;
  assign sum     = {1'b0, cur.acc} + {1'b0, add_b} + {{DataW{1'b0}}, cur.c};

  assign cmp_reg = (op == OP_CPX) ? cur.idx_x : (op == OP_CPY) ? cur.idx_y : cur.acc;
  assign diff    = {1'b0, cmp_reg} - {1'b0, m};

  assign inc_val = m + 8'd1;
  assign dec_val = m - 8'd1;

  always_comb begin
    nxt = cur;
    we  = 1'b0;
    wd  = '0;
    unique case (op)
      OP_LDA: begin
        nxt.acc = m;
        nxt.n   = m[DataW-1];
        nxt.z   = (m == '0);
      end
      OP_LDX: begin
        nxt.idx_x = m;
        nxt.n     = m[DataW-1];
        nxt.z     = (m == '0);
      end
      OP_LDY: begin
        nxt.idx_y = m;
        nxt.n     = m[DataW-1];
        nxt.z     = (m == '0);
      end
      OP_STA: begin
        we = 1'b1;
        wd = cur.acc;
      end
      OP_STX: begin
        we = 1'b1;
        wd = cur.idx_x;
      end
      OP_STY: begin
        we = 1'b1;
        wd = cur.idx_y;
      end
      OP_AND: begin
        nxt.acc = cur.acc & m;
        nxt.n   = nxt.acc[DataW-1];
        nxt.z   = (nxt.acc == '0);
      end
      OP_EOR: begin
        nxt.acc = cur.acc ^ m;
        nxt.n   = nxt.acc[DataW-1];
        nxt.z   = (nxt.acc == '0);
      end
      OP_ORA: begin
        nxt.acc = cur.acc | m;
        nxt.n   = nxt.acc[DataW-1];
        nxt.z   = (nxt.acc == '0);
      end
      OP_BIT: begin
        nxt.z = ((cur.acc & m) == '0);
        nxt.n = m[DataW-1];
        nxt.v = m[DataW-2];
      end
      OP_ADC, OP_SBC: begin
        nxt.acc = sum[DataW-1:0];
        nxt.c   = sum[DataW];
        // signed overflow: operands agree in sign, result differs
        nxt.v   = ~(cur.acc[DataW-1] ^ add_b[DataW-1]) &
                  (cur.acc[DataW-1] ^ sum[DataW-1]);
        nxt.n   = sum[DataW-1];
        nxt.z   = (sum[DataW-1:0] == '0);
      end
      OP_CMP, OP_CPX, OP_CPY: begin
        nxt.c = ~diff[DataW];
        nxt.z = (cmp_reg == m);
        nxt.n = diff[DataW-1];
      end
      OP_INC: begin
        we    = 1'b1;
        wd    = inc_val;
        nxt.n = inc_val[DataW-1];
        nxt.z = (inc_val == '0);
      end
      OP_DEC: begin
        we    = 1'b1;
        wd    = dec_val;
        nxt.n = dec_val[DataW-1];
        nxt.z = (dec_val == '0);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    rsp.write_enable  = we;
    rsp.write_address = we ? req.operand_address : '0;
    rsp.write_data    = wd;
    rsp.acc_out       = nxt.acc;
    rsp.index_x_out   = nxt.idx_x;
    rsp.index_y_out   = nxt.idx_y;
    rsp.negative_flag = nxt.n;
    rsp.overflow_flag = nxt.v;
    rsp.zero_flag     = nxt.z;
    rsp.carry_flag    = nxt.c;
  end

endmodule

### design/byte_cpu_alu_execute.sv
// Top level of the byte CPU execute unit: input register, datapath, result
// register and the A/X/Y/flag registers. Depends on bcae_pkg and bcae_alu.
//
//   channel | signals                       | payload
//   --------+-------------------------------+----------------------------
//   input   | in_valid, in_ready, in_data   | req_t  (one instruction)
//   output  | out_valid, out_ready, out_data| rsp_t  (write + regs/flags)
//
// An instruction is held in the input register, takes a single datapath pass
// and is captured in the result register; one instruction per cycle is
// sustained while the output is not stalled.
// A, X, Y and the flags update when the instruction moves into the result
// register, so the next instruction sees them at once.
// Reset clears A, X, Y, the flags and both valid bits, not the data registers.
// A stalled output holds the result; the input register still takes one more.

module byte_cpu_alu_execute import bcae_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output rsp_t out_data
);

  req_t  req_q;
  logic  req_vld;
  arch_t arch;
  rsp_t  rsp_next;
  logic  advance;

  // Move the held instruction on whenever the result register is free
  assign advance  = req_vld && (!out_valid || out_ready);
  assign in_ready = !req_vld || advance;

  bcae_alu u_alu (
    .req (req_q),
    .cur (arch),
    .rsp (rsp_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      req_vld <= 1'b0;
    end else if (in_ready) begin
      req_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_q <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= rsp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      arch <= '0;
    end else if (advance) begin
      arch.acc   <= rsp_next.acc_out;
      arch.idx_x <= rsp_next.index_x_out;
      arch.idx_y <= rsp_next.index_y_out;
      arch.n     <= rsp_next.negative_flag;
      arch.v     <= rsp_next.overflow_flag;
      arch.z     <= rsp_next.zero_flag;
      arch.c     <= rsp_next.carry_flag;
    end
  end

`ifndef SYNTH
  a_adv_fills_out: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("result register not loaded after transfer");

  a_arch_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(arch))
    else $error("registers changed without an instruction");

  a_out_mirrors_arch: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.acc_out == arch.acc && out_data.index_x_out == arch.idx_x &&
                   out_data.index_y_out == arch.idx_y && out_data.carry_flag == arch.c))
    else $error("result disagrees with register state");

  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.write_enable |->
      (out_data.write_address == '0 && out_data.write_data == '0))
    else $error("write fields not cleared without write");
`endif

endmodule
